// ===== design/fire_heat_propagation_defines.svh =====
// assertion macros shared by the fire heat checker
`ifndef FIRE_HEAT_PROPAGATION_DEFINES_SVH
`define FIRE_HEAT_PROPAGATION_DEFINES_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define FHP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define FHP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fhp_pkg.sv =====
package fhp_pkg;

	// field widths
	localparam int HEAT_W     = 8;
	localparam int COL_W      = 10;
	localparam int ROW_W      = 10;
	localparam int GAIN_W     = 15;
	localparam int GEOM_W     = 11;
	localparam int BONUS_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// default geometry limits
	localparam int MAX_ROW_LENGTH_DEF = 1024;
	localparam int MAX_ROWS_DEF       = 1024;

	// register reset values
	localparam logic [GAIN_W-1:0]  GAIN_RESET        = 15'd21629;
	localparam logic [GEOM_W-1:0]  ROW_LENGTH_RESET  = 11'd640;
	localparam logic [GEOM_W-1:0]  ROW_COUNT_RESET   = 11'd480;
	localparam logic [BONUS_W-1:0] SPARK_BONUS_RESET = 4'd2;

	// hottest cell
	localparam logic [HEAT_W-1:0] HEAT_MAX = 8'd255;

	// command codes
	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN        = 2'd0,
		REG_ROW_LENGTH  = 2'd1,
		REG_ROW_COUNT   = 2'd2,
		REG_SPARK_BONUS = 2'd3
	} reg_idx_t;

endpackage

// ===== design/fhp_if.sv =====
// command word channel
interface fhp_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [fhp_pkg::HEAT_W-1:0]  seed_heat;
	logic                        spark;

	modport source (output valid, cmd, seed_heat, spark, input ready);
	modport sink   (input valid, cmd, seed_heat, spark, output ready);
endinterface

// heat word channel
interface fhp_heat_if;
	logic                        valid;
	logic                        ready;
	logic [fhp_pkg::HEAT_W-1:0]  heat;
	logic [fhp_pkg::COL_W-1:0]   column;
	logic [fhp_pkg::ROW_W-1:0]   row;
	logic                        row_done;
	logic                        frame_done;

	modport source (output valid, heat, column, row, row_done, frame_done, input ready);
	modport sink   (input valid, heat, column, row, row_done, frame_done, output ready);
endinterface

// ===== design/fire_heat_propagation.sv =====
// Fire heat field generator. Load words (cmd 0) fill the seed row, the bottom row of the
// frame, one cell per word; compute words (cmd 1) each return one heat word, walking the
// frame from row row_count-2 up to row 0 and, within a row, from the right end to column 0.
// A cell is the sum of its three lower neighbours times the Q0.16 gain, truncated, plus the
// spark bonus when spark is set, saturated at 255. The seed row and the row below the
// current one sit in two RAMs with two registered read ports each, so every cell needs a
// single read and the block takes one word per clock, sustained, while the consumer
// keeps up; a heat word passes from the read stage into the output register, from which
// it is offered; the cell written back in the same cycle is forwarded to the following
// read. Neither RAM is cleared after reset: computing a frame before the seed row has been
// loaded gives undefined heat. Writing row_length or row_count restarts the walk at the
// start of a frame and rewinds the seed load position; gain and spark_bonus take effect on
// the next word.
module fire_heat_propagation #(
	parameter int MAX_ROW_LENGTH = fhp_pkg::MAX_ROW_LENGTH_DEF,
	parameter int MAX_ROWS       = fhp_pkg::MAX_ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	fhp_cmd_if.sink                          cmd_ch,
	fhp_heat_if.source                       heat_ch,
	input  logic                             cfg_we,
	input  logic [fhp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fhp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW = $clog2(MAX_ROW_LENGTH);
	localparam int RW = $clog2(MAX_ROWS);
	localparam int LW = $clog2(MAX_ROW_LENGTH + 1);
	localparam int NW = $clog2(MAX_ROWS + 1);
	localparam int HW = fhp_pkg::HEAT_W;
	localparam int SUM_W = HW + 2;
	localparam int PROD_W = SUM_W + fhp_pkg::GAIN_W;
	localparam int RST_LEN = (int'(fhp_pkg::ROW_LENGTH_RESET) > MAX_ROW_LENGTH)
		? MAX_ROW_LENGTH : int'(fhp_pkg::ROW_LENGTH_RESET);
	localparam int RST_ROWS = (int'(fhp_pkg::ROW_COUNT_RESET) > MAX_ROWS)
		? MAX_ROWS : int'(fhp_pkg::ROW_COUNT_RESET);

	// configuration registers
	logic [fhp_pkg::GAIN_W-1:0]  gain_q;
	logic [fhp_pkg::GEOM_W-1:0]  row_length_q;
	logic [fhp_pkg::GEOM_W-1:0]  row_count_q;
	logic [fhp_pkg::BONUS_W-1:0] spark_bonus_q;
	logic                        geom_wr;

	assign geom_wr = cfg_we && (cfg_index == fhp_pkg::REG_ROW_LENGTH
		|| cfg_index == fhp_pkg::REG_ROW_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= fhp_pkg::GAIN_RESET;
			row_length_q  <= fhp_pkg::ROW_LENGTH_RESET;
			row_count_q   <= fhp_pkg::ROW_COUNT_RESET;
			spark_bonus_q <= fhp_pkg::SPARK_BONUS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				fhp_pkg::REG_GAIN:        gain_q        <= cfg_data[fhp_pkg::GAIN_W-1:0];
				fhp_pkg::REG_ROW_LENGTH:  row_length_q  <= cfg_data[fhp_pkg::GEOM_W-1:0];
				fhp_pkg::REG_ROW_COUNT:   row_count_q   <= cfg_data[fhp_pkg::GEOM_W-1:0];
				fhp_pkg::REG_SPARK_BONUS: spark_bonus_q <= cfg_data[fhp_pkg::BONUS_W-1:0];
				default: ;
			endcase
		end
	end

	// geometry in use, at least 2 and clamped to what the stores hold
	logic [LW-1:0] len;
	logic [NW-1:0] rows;
	logic [CW-1:0] last_col;
	logic [RW-1:0] top_row;

	always_comb begin
		if (row_length_q < 11'd2) begin
			len = LW'(2);
		end else if (int'(row_length_q) > MAX_ROW_LENGTH) begin
			len = LW'(MAX_ROW_LENGTH);
		end else begin
			len = LW'(row_length_q);
		end
		if (row_count_q < 11'd2) begin
			rows = NW'(2);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows = NW'(MAX_ROWS);
		end else begin
			rows = NW'(row_count_q);
		end
	end

	assign last_col = CW'(len - LW'(1));
	assign top_row  = RW'(rows - NW'(2));

	// handshake
	logic valid_s1;
	logic s1_adv;
	logic out_valid_q;
	logic acc;
	logic load_acc;
	logic comp_acc;

	assign s1_adv       = valid_s1 && (!out_valid_q || heat_ch.ready);
	assign cmd_ch.ready = !valid_s1 || s1_adv;
	assign acc          = cmd_ch.valid && cmd_ch.ready;
	assign load_acc     = acc && (cmd_ch.cmd == fhp_pkg::CMD_LOAD);
	assign comp_acc     = acc && (cmd_ch.cmd == fhp_pkg::CMD_COMPUTE);

	// walk position, with a pending restart after a geometry write
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          restart_q;
	logic [CW-1:0] seed_ptr_q;
	logic [CW-1:0] cur_c;
	logic [RW-1:0] cur_r;
	logic          cur_seed;

	assign cur_c    = restart_q ? last_col : col_q;
	assign cur_r    = restart_q ? top_row : row_q;
	assign cur_seed = (cur_r == top_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= CW'(RST_LEN - 1);
			row_q      <= RW'(RST_ROWS - 2);
			restart_q  <= 1'b0;
			seed_ptr_q <= '0;
		end else if (geom_wr) begin
			restart_q  <= 1'b1;
			seed_ptr_q <= '0;
		end else if (load_acc) begin
			seed_ptr_q <= (seed_ptr_q == last_col) ? '0 : seed_ptr_q + CW'(1);
		end else if (comp_acc) begin
			restart_q <= 1'b0;
			if (cur_c != '0) begin
				col_q <= cur_c - CW'(1);
				row_q <= cur_r;
			end else if (cur_r != '0) begin
				col_q <= last_col;
				row_q <= cur_r - RW'(1);
			end else begin
				col_q <= last_col;
				row_q <= top_row;
			end
		end
	end

	// stores: seed row and the row below the current one
	logic [HW-1:0] seed_mid;
	logic [HW-1:0] seed_left;
	logic [HW-1:0] line_mid;
	logic [HW-1:0] line_left;
	logic [HW-1:0] heat_new;
	logic [CW-1:0] c_s1;

	fhp_ram #(.WIDTH(HW), .DEPTH(MAX_ROW_LENGTH)) u_seed_ram (
		.clk     (clk),
		.we      (load_acc),
		.waddr   (seed_ptr_q),
		.wdata   (cmd_ch.seed_heat),
		.re      (comp_acc),
		.raddr_a (cur_c),
		.raddr_b (cur_c - CW'(1)),
		.rdata_a (seed_mid),
		.rdata_b (seed_left)
	);

	fhp_ram #(.WIDTH(HW), .DEPTH(MAX_ROW_LENGTH)) u_line_ram (
		.clk     (clk),
		.we      (s1_adv),
		.waddr   (c_s1),
		.wdata   (heat_new),
		.re      (comp_acc),
		.raddr_a (cur_c),
		.raddr_b (cur_c - CW'(1)),
		.rdata_a (line_mid),
		.rdata_b (line_left)
	);

	// read stage: cell position and bypass flags for a write landing on the same edge
	logic [RW-1:0] r_s1;
	logic          seed_s1;
	logic          first_s1;
	logic          spark_s1;
	logic          hit_mid_s1;
	logic          hit_left_s1;
	logic [HW-1:0] fwd_q;
	logic [HW-1:0] right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (comp_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (comp_acc) begin
			c_s1        <= cur_c;
			r_s1        <= cur_r;
			seed_s1     <= cur_seed;
			first_s1    <= (cur_c == last_col);
			spark_s1    <= cmd_ch.spark;
			hit_mid_s1  <= s1_adv && !cur_seed && (cur_c == c_s1);
			hit_left_s1 <= s1_adv && !cur_seed && (cur_c != '0)
				&& ((cur_c - CW'(1)) == c_s1);
		end
		if (s1_adv) begin
			fwd_q <= heat_new;
		end
	end

	// neighbours, sum, gain and spark
	logic [HW-1:0]              mid;
	logic [HW-1:0]              left;
	logic [HW-1:0]              right;
	logic [SUM_W-1:0]           sum;
	logic [PROD_W-1:0]          prod;
	logic [SUM_W-1:0]           boosted;

	always_comb begin
		if (hit_mid_s1) begin
			mid = fwd_q;
		end else begin
			mid = seed_s1 ? seed_mid : line_mid;
		end
		if (c_s1 == '0) begin
			left = '0;
		end else if (hit_left_s1) begin
			left = fwd_q;
		end else begin
			left = seed_s1 ? seed_left : line_left;
		end
		right   = first_s1 ? '0 : right_q;
		sum     = SUM_W'(left) + SUM_W'(mid) + SUM_W'(right);
		prod    = PROD_W'(sum) * PROD_W'(gain_q);
		boosted = SUM_W'(prod[PROD_W-1:16])
			+ (spark_s1 ? SUM_W'(spark_bonus_q) : SUM_W'(0));
		heat_new = (boosted > SUM_W'(fhp_pkg::HEAT_MAX)) ? fhp_pkg::HEAT_MAX : boosted[HW-1:0];
	end

	// the old cell below becomes the right neighbour of the next cell
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			right_q <= mid;
		end
	end

	// output register
	logic [HW-1:0]               heat_q;
	logic [fhp_pkg::COL_W-1:0]   column_q;
	logic [fhp_pkg::ROW_W-1:0]   row_out_q;
	logic                        row_done_q;
	logic                        frame_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (heat_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			heat_q       <= heat_new;
			column_q     <= fhp_pkg::COL_W'(c_s1);
			row_out_q    <= fhp_pkg::ROW_W'(r_s1);
			row_done_q   <= (c_s1 == '0);
			frame_done_q <= (c_s1 == '0) && (r_s1 == '0);
		end
	end

	assign heat_ch.valid      = out_valid_q;
	assign heat_ch.heat       = heat_q;
	assign heat_ch.column     = column_q;
	assign heat_ch.row        = row_out_q;
	assign heat_ch.row_done   = row_done_q;
	assign heat_ch.frame_done = frame_done_q;

endmodule

// ===== design/fhp_ram.sv =====
module fhp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, two registered read ports, old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== design/fhp_checker.sv =====
`include "fire_heat_propagation_defines.svh"

module fhp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_ready,
	input logic                           heat_valid,
	input logic                           heat_ready,
	input logic [fhp_pkg::COL_W-1:0]      column,
	input logic [fhp_pkg::ROW_W-1:0]      row,
	input logic                           row_done,
	input logic                           frame_done,
	input logic                           cfg_we,
	input logic [fhp_pkg::CFG_IDX_W-1:0]  cfg_index
);

	logic                       out_acc;
	logic                       have_q;
	logic                       last_rd_q;
	logic [fhp_pkg::COL_W-1:0]  last_col_q;

	assign out_acc = heat_valid && heat_ready;

	// previous heat word, forgotten when the geometry is rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q    <= 1'b0;
			last_rd_q <= 1'b0;
		end else if (cfg_we && (cfg_index == fhp_pkg::REG_ROW_LENGTH
				|| cfg_index == fhp_pkg::REG_ROW_COUNT)) begin
			have_q <= 1'b0;
		end else if (out_acc) begin
			have_q    <= 1'b1;
			last_rd_q <= row_done;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			last_col_q <= column;
		end
	end

	// a stalled heat word stays offered
	`FHP_ASSERT_NXT(a_heat_hold, heat_valid && !heat_ready, heat_valid, "heat word dropped")

	// an empty output never blocks the command side
	`FHP_ASSERT_IMP(a_ready_when_empty, !heat_valid && cmd_valid, cmd_ready, "input stalled")

	// within a row the walk steps one column to the left
	`FHP_ASSERT_IMP(a_column_step, out_acc && have_q && !last_rd_q, column == last_col_q - 10'd1, "column skipped")

	// frame end only at the top left cell
	`FHP_ASSERT_IMP(a_frame_end, heat_valid && frame_done, row_done && row == '0 && column == '0, "bad frame end")

endmodule

bind fire_heat_propagation fhp_checker u_fhp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd_ch.valid),
	.cmd_ready  (cmd_ch.ready),
	.heat_valid (heat_ch.valid),
	.heat_ready (heat_ch.ready),
	.column     (heat_ch.column),
	.row        (heat_ch.row),
	.row_done   (heat_ch.row_done),
	.frame_done (heat_ch.frame_done),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import fhp_pkg::*;

	localparam int      HALF_PERIOD = 10;
	localparam int      LATENCY_PAD = 8;
	localparam int      HOLD_CYCLES = 300;
	localparam int      DRAIN_LIMIT = 5000;
	localparam longint  RUN_LIMIT   = 64'd40_000_000;
	localparam int      MAX_LEN     = MAX_ROW_LENGTH_DEF;
	localparam int      MAX_ROWS    = MAX_ROWS_DEF;

	typedef struct packed {
		logic [HEAT_W-1:0] heat;
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic              row_done;
		logic              frame_done;
	} heat_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fhp_cmd_if  cmd_ch();
	fhp_heat_if heat_ch();

	fire_heat_propagation u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.heat_ch   (heat_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// fire field predictor state
	logic [GAIN_W-1:0]  fire_gain;
	logic [GEOM_W-1:0]  fire_row_length;
	logic [GEOM_W-1:0]  fire_row_count;
	logic [BONUS_W-1:0] fire_bonus;
	logic [HEAT_W-1:0]  seed_cells [MAX_LEN];
	bit                 seed_written [MAX_LEN];
	logic [HEAT_W-1:0]  line_cells [MAX_LEN];
	logic [HEAT_W-1:0]  right_below;
	int unsigned        seed_pos;
	int unsigned        walk_col;
	int unsigned        walk_row;

	heat_word_t heat_expected [$];

	bit idle_on  = 1'b1;
	bit hold_req = 1'b0;
	int n_errors = 0;
	int n_words  = 0;
	int n_loads  = 0;
	int n_cells  = 0;
	int n_frames = 0;
	int n_phases = 0;

	function automatic int unsigned used_length();
		if (fire_row_length < 2) return 2;
		if (fire_row_length > MAX_LEN) return MAX_LEN;
		return fire_row_length;
	endfunction

	function automatic int unsigned used_rows();
		if (fire_row_count < 2) return 2;
		if (fire_row_count > MAX_ROWS) return MAX_ROWS;
		return fire_row_count;
	endfunction

	function automatic void restart_walk();
		walk_col    = used_length() - 1;
		walk_row    = used_rows() - 2;
		right_below = '0;
	endfunction

	function automatic void fire_reset();
		fire_gain       = GAIN_RESET;
		fire_row_length = ROW_LENGTH_RESET;
		fire_row_count  = ROW_COUNT_RESET;
		fire_bonus      = SPARK_BONUS_RESET;
		foreach (seed_written[i]) seed_written[i] = 1'b0;
		seed_pos = 0;
		restart_walk();
	endfunction

	function automatic void fire_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_GAIN: begin
				fire_gain = data[GAIN_W-1:0];
			end
			REG_ROW_LENGTH: begin
				fire_row_length = data[GEOM_W-1:0];
				seed_pos = 0;
				restart_walk();
			end
			REG_ROW_COUNT: begin
				fire_row_count = data[GEOM_W-1:0];
				seed_pos = 0;
				restart_walk();
			end
			REG_SPARK_BONUS: begin
				fire_bonus = data[BONUS_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void seed_store(input logic [HEAT_W-1:0] value);
		int unsigned len;
		len = used_length();
		if (seed_pos >= len) seed_pos = 0;
		seed_cells[seed_pos]   = value;
		seed_written[seed_pos] = 1'b1;
		seed_pos++;
		if (seed_pos >= len) seed_pos = 0;
	endfunction

	// every seed cell of the row in use has been loaded
	function automatic bit seed_complete();
		for (int i = 0; i < used_length(); i++)
			if (!seed_written[i]) return 1'b0;
		return 1'b1;
	endfunction

	// next cell of the walk: three cells below, gain, spark, saturation
	function automatic heat_word_t next_heat_cell(input logic spark);
		int unsigned len, rows, c, r, lft, mid, rgt, sum, h;
		heat_word_t w;
		len  = used_length();
		rows = used_rows();
		if (walk_col >= len || walk_row > rows - 2) restart_walk();
		c = walk_col;
		r = walk_row;
		if (r == rows - 2) begin
			mid = seed_cells[c];
			lft = (c > 0) ? seed_cells[c-1] : 0;
		end else begin
			mid = line_cells[c];
			lft = (c > 0) ? line_cells[c-1] : 0;
		end
		rgt = (c + 1 < len) ? right_below : 0;
		sum = lft + mid + rgt;
		h = (sum * fire_gain) >> 16;
		if (spark) h += fire_bonus;
		if (h > HEAT_MAX) h = HEAT_MAX;
		right_below   = mid[HEAT_W-1:0];
		line_cells[c] = h[HEAT_W-1:0];
		w.heat       = h[HEAT_W-1:0];
		w.column     = c[COL_W-1:0];
		w.row        = r[ROW_W-1:0];
		w.row_done   = (c == 0);
		w.frame_done = (c == 0 && r == 0);
		if (c > 0) begin
			walk_col = c - 1;
		end else if (r > 0) begin
			walk_col    = len - 1;
			walk_row    = r - 1;
			right_below = '0;
		end else begin
			restart_walk();
		end
		return w;
	endfunction

	function automatic logic [HEAT_W-1:0] pick_seed();
		case ($urandom_range(0, 4))
			0, 1: return '0;
			2, 3: return HEAT_MAX;
			default: return HEAT_W'($urandom);
		endcase
	endfunction

	function automatic logic [GEOM_W-1:0] pick_extent(input int hi);
		case ($urandom_range(0, 9))
			0: return GEOM_W'($urandom_range(0, 1));
			1: return GEOM_W'($urandom_range(hi + 1, 40));
			default: return GEOM_W'($urandom_range(2, hi));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 15'd21845;
			2: return 15'd32767;
			3: return GAIN_RESET;
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	// one register write; unused upper data bits sometimes carry junk
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] data;
		int                    width;
		case (idx)
			REG_GAIN:        width = GAIN_W;
			REG_SPARK_BONUS: width = BONUS_W;
			default:         width = GEOM_W;
		endcase
		data = value;
		if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
			data = data | (CFG_DATA_W'($urandom) << width);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		fire_write(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// block drained and quiet
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (heat_expected.size() != 0) @(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	// send one command word and predict its effect at acceptance
	task automatic send_word(input logic cmd, input logic [HEAT_W-1:0] seed, input logic spark);
		int         gap;
		heat_word_t w;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.cmd       <= cmd;
		cmd_ch.seed_heat <= seed;
		cmd_ch.spark     <= spark;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		n_words++;
		if (cmd == CMD_COMPUTE) begin
			w = next_heat_cell(spark);
			heat_expected = {heat_expected, w};
			n_cells++;
		end else begin
			seed_store(seed);
			n_loads++;
		end
	endtask

	task automatic set_registers(input logic [GEOM_W-1:0] len, input logic [GEOM_W-1:0] rows,
	                             input logic [GAIN_W-1:0] g, input logic [BONUS_W-1:0] b,
	                             input bit geom);
		wait_idle();
		write_reg(REG_GAIN, g);
		if (geom) begin
			write_reg(REG_ROW_LENGTH, len);
			write_reg(REG_ROW_COUNT, rows);
		end
		write_reg(REG_SPARK_BONUS, b);
		n_phases++;
	endtask

	// seed row (full, partial or none, then topped up to complete) then heat cells, with loads mixed in unless holding
	task automatic feed_cells(input int reload, input int cells, input bit hold);
		int k, n, len;
		len = used_length();
		if (reload < 0) k = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : len;
		else            k = reload ? len : 0;
		for (int i = 0; i < k; i++) send_word(CMD_LOAD, pick_seed(), 1'($urandom));
		while (!seed_complete()) send_word(CMD_LOAD, pick_seed(), 1'($urandom));
		if (cells < 0) begin
			cells = len * (used_rows() - 1) * $urandom_range(1, 2) + $urandom_range(0, 3);
			if (cells > 20) cells = 20;
		end
		if (hold) hold_req = 1'b1;
		n = 0;
		while (n < cells) begin
			if (!hold && $urandom_range(0, 9) == 0) begin
				send_word(CMD_LOAD, pick_seed(), 1'($urandom));
			end else begin
				send_word(CMD_COMPUTE, HEAT_W'($urandom), $urandom_range(0, 3) == 0);
				n++;
			end
		end
	endtask

	// reset geometry, gain and bonus before any write
	task automatic test_reset_values();
		feed_cells(1, 4, 1'b0);
	endtask

	// edges, saturation, zero gain, clamped small geometry, frame wrap
	task automatic test_directed();
		set_registers(3, 3, 15'd21845, 4'd15, 1'b1);
		send_word(CMD_LOAD, HEAT_MAX, 1'b1);
		send_word(CMD_LOAD, 8'd0, 1'b0);
		send_word(CMD_LOAD, HEAT_MAX, 1'b1);
		for (int i = 0; i < 7; i++) send_word(CMD_COMPUTE, 8'd0, i[0]);
		set_registers(3, 3, 15'd32767, 4'd15, 1'b1);
		repeat (3) send_word(CMD_LOAD, HEAT_MAX, 1'b0);
		repeat (3) send_word(CMD_COMPUTE, HEAT_MAX, 1'b1);
		set_registers(3, 3, 15'd0, 4'd0, 1'b0);
		send_word(CMD_COMPUTE, 8'h55, 1'b1);
		send_word(CMD_COMPUTE, 8'hAA, 1'b0);
		set_registers(11'd1, 11'd0, GAIN_RESET, 4'd8, 1'b1);
		send_word(CMD_LOAD, 8'h80, 1'b0);
		send_word(CMD_LOAD, 8'h7F, 1'b1);
		repeat (3) send_word(CMD_COMPUTE, 8'hFF, 1'b1);
	endtask

	// random settings, often changed in the middle of a frame
	task automatic test_random_settings();
		int start;
		start = n_words;
		while (n_words - start < 40) begin
			set_registers(pick_extent(12), pick_extent(5), pick_gain(), BONUS_W'($urandom),
			              $urandom_range(0, 3) != 0);
			feed_cells(-1, -1, 1'b0);
		end
	endtask

	// row count beyond the largest size, and the smallest frame
	task automatic test_clamped_geometry();
		set_registers(11'd6, 11'd2047, pick_gain(), BONUS_W'($urandom), 1'b1);
		feed_cells(1, 14, 1'b0);
		set_registers(11'd2, 11'd2, pick_gain(), BONUS_W'($urandom), 1'b1);
		feed_cells(-1, 8, 1'b0);
	endtask

	// receiver holds off while words keep coming
	task automatic test_backpressure();
		set_registers(11'd4, 11'd4, GAIN_RESET, SPARK_BONUS_RESET, 1'b1);
		feed_cells(1, 20, 1'b1);
	endtask

	// full rate, no idling on either side
	task automatic test_steady_rate();
		wait_idle();
		idle_on = 1'b0;
		set_registers(pick_extent(12), pick_extent(5), pick_gain(), BONUS_W'($urandom), 1'b1);
		feed_cells(1, 24, 1'b0);
	endtask

	// receiver ready: random stall bursts and the long hold-off
	initial begin : heat_sink
		int n;
		heat_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				heat_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				heat_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 14);
				heat_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
				heat_ch.ready <= 1'b1;
			end else begin
				heat_ch.ready <= 1'b1;
			end
		end
	end

	task automatic report_mismatch(input string what, input heat_word_t exp_w,
	                               input heat_word_t got_w);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch %s: expected heat %0d col %0d row %0d rd %0b fd %0b, got heat %0d col %0d row %0d rd %0b fd %0b",
			         what, exp_w.heat, exp_w.column, exp_w.row, exp_w.row_done, exp_w.frame_done,
			         got_w.heat, got_w.column, got_w.row, got_w.row_done, got_w.frame_done);
	endtask

	// compare each heat word with the oldest expectation
	always @(posedge clk) begin : heat_check
		heat_word_t got_w, exp_w;
		if (arst_n && heat_ch.valid === 1'b1 && heat_ch.ready === 1'b1) begin
			got_w = {heat_ch.heat, heat_ch.column, heat_ch.row, heat_ch.row_done,
			         heat_ch.frame_done};
			if (heat_expected.size() == 0) begin
				report_mismatch("unexpected word", '0, got_w);
			end else begin
				exp_w = heat_expected.pop_front();
				if (got_w !== exp_w) report_mismatch("heat word", exp_w, got_w);
				if (exp_w.frame_done) n_frames++;
			end
		end
	end

	initial begin : run_limit
		#(RUN_LIMIT);
		$display("[fire_heat_propagation] ERROR");
		$finish;
	end

	initial begin : test_seq
		int i;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.cmd       <= CMD_LOAD;
		cmd_ch.seed_heat <= '0;
		cmd_ch.spark     <= 1'b0;
		fire_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed();
		test_random_settings();
		test_clamped_geometry();
		test_backpressure();
		test_steady_rate();

		// drain and let the pipeline settle
		cmd_ch.valid <= 1'b0;
		for (i = 0; i < DRAIN_LIMIT && heat_expected.size() != 0; i++) @(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
		if (heat_expected.size() != 0) begin
			n_errors++;
			$display("%0d heat words never arrived", heat_expected.size());
		end

		$display("covered %0d words: %0d seed loads, %0d heat cells, %0d frames completed",
		         n_words, n_loads, n_cells, n_frames);
		$display("over %0d register settings incl. clamped geometry and receiver hold-off; %0d mismatches",
		         n_phases, n_errors);
		if (n_errors == 0)
			$display("[fire_heat_propagation] OK");
		else
			$display("[fire_heat_propagation] ERROR");
		$finish;
	end

endmodule
